/* hdl/assert_macros.svh */
// Assertion macros shared by the reply reorder buffer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge of clk while rst_n is high.
`define RRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that expr never holds while rst_n is high.
`define RRB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hdl/rrb_pkg.sv */
// Shared widths, result codes and result record of the reply reorder buffer.
// No dependencies; used by the interfaces, the slot memory and the controller.
package rrb_pkg;

    localparam int ID_W  = 16;
    localparam int PAY_W = 16;

    typedef enum logic [1:0] {
        KIND_GRANT    = 2'd0,
        KIND_WRITTEN  = 2'd1,
        KIND_REJECTED = 2'd2,
        KIND_FULL     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [PAY_W-1:0]  payload;
        logic              last;
    } result_t;

endpackage

/* hdl/rrb_if.sv */
// Valid/ready channel interfaces: request input, result output, config write.
// Depends on rrb_pkg.
interface rrb_in_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [rrb_pkg::ID_W-1:0]  reply_id;
    logic [rrb_pkg::PAY_W-1:0] payload_handle;

    modport source (output valid, req_type, reply_id, payload_handle, input ready);
    modport sink   (input valid, req_type, reply_id, payload_handle, output ready);
endinterface

interface rrb_out_if;
    logic                     valid;
    logic                     ready;
    rrb_pkg::kind_t           out_kind;
    logic [rrb_pkg::ID_W-1:0]  out_id;
    logic [rrb_pkg::PAY_W-1:0] out_payload;
    logic                     last;

    modport source (output valid, out_kind, out_id, out_payload, last, input ready);
    modport sink   (input valid, out_kind, out_id, out_payload, last, output ready);
endinterface

interface rrb_cfg_if;
    logic valid;
    logic ready;
    logic out_of_order;

    modport source (output valid, out_of_order, input ready);
    modport sink   (input valid, out_of_order, output ready);
endinterface

/* hdl/rrb_slot_mem.sv */
// Slot store: one valid bit and one payload handle per window entry.
// Single write port, single read port, registered read data. Depends on rrb_pkg.
module rrb_slot_mem #(
    parameter int WINDOW = 32
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(WINDOW)-1:0]    rd_addr,
    output logic [rrb_pkg::PAY_W:0]      rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(WINDOW)-1:0]    wr_addr,
    input  logic [rrb_pkg::PAY_W:0]      wr_data
);
    import rrb_pkg::*;

    logic [PAY_W:0] slot_mem_reg [WINDOW];
    logic [PAY_W:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem_reg[wr_addr] <= wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/rrb_ctrl.sv */
// Sequencer of the reply reorder buffer: id window, slot lookups, drain, result register.
// Depends on rrb_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module rrb_ctrl #(
    parameter int WINDOW = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    rrb_in_if.sink                       req,
    rrb_out_if.source                    rsp,
    rrb_cfg_if.sink                      cfg,
    output logic                         mem_rd_en,
    output logic [$clog2(WINDOW)-1:0]    mem_rd_addr,
    input  logic [rrb_pkg::PAY_W:0]      mem_rd_data,
    output logic                         mem_wr_en,
    output logic [$clog2(WINDOW)-1:0]    mem_wr_addr,
    output logic [rrb_pkg::PAY_W:0]      mem_wr_data
);
    import rrb_pkg::*;

    localparam int SW = $clog2(WINDOW);
    localparam logic [ID_W-1:0] WIN_ID    = ID_W'(WINDOW);
    localparam logic [SW-1:0]   LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [SW:0]     WIN_EXT   = (SW + 1)'(WINDOW);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic             ooo_reg;
    logic [ID_W-1:0]  head_id_reg, head_id_next;
    logic [ID_W-1:0]  tail_id_reg, tail_id_next;
    logic [SW-1:0]    head_slot_reg, head_slot_next;
    logic [SW-1:0]    clr_idx_reg, clr_idx_next;

    logic             item_reply_reg, item_reply_next;
    logic [ID_W-1:0]  item_id_reg, item_id_next;
    logic [PAY_W-1:0] item_pay_reg, item_pay_next;
    logic             item_zero_reg, item_zero_next;
    logic             item_win_reg, item_win_next;
    logic [SW-1:0]    item_slot_reg, item_slot_next;

    logic [ID_W-1:0]  pend_id_reg, pend_id_next;
    logic [PAY_W-1:0] pend_pay_reg, pend_pay_next;

    result_t          out_reg;
    logic             out_valid_reg;

    logic [ID_W-1:0]  used;
    logic [ID_W-1:0]  offset;
    logic             in_win;
    logic [SW:0]      slot_sum;
    logic [SW-1:0]    req_slot;
    logic [SW-1:0]    head_slot_inc;
    logic             can_push;
    logic             push;
    result_t          push_val;
    logic             accept;
    logic             drain_more;

    assign used          = tail_id_reg - head_id_reg;
    assign offset        = req.reply_id - head_id_reg;
    assign in_win        = offset < used;
    assign slot_sum      = {1'b0, head_slot_reg} + {1'b0, offset[SW-1:0]};
    assign head_slot_inc = (head_slot_reg == LAST_SLOT) ? '0 : head_slot_reg + 1'b1;
    assign can_push      = !out_valid_reg || rsp.ready;
    assign accept        = req.valid && req.ready;
    assign drain_more    = (head_id_reg != tail_id_reg) && mem_rd_data[PAY_W];

    always_comb
    begin
        if (!in_win)
        begin
            req_slot = '0;
        end
        else if (slot_sum >= WIN_EXT)
        begin
            req_slot = SW'(slot_sum - WIN_EXT);
        end
        else
        begin
            req_slot = slot_sum[SW-1:0];
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        head_id_next    = head_id_reg;
        tail_id_next    = tail_id_reg;
        head_slot_next  = head_slot_reg;
        clr_idx_next    = clr_idx_reg;
        item_reply_next = item_reply_reg;
        item_id_next    = item_id_reg;
        item_pay_next   = item_pay_reg;
        item_zero_next  = item_zero_reg;
        item_win_next   = item_win_reg;
        item_slot_next  = item_slot_reg;
        pend_id_next    = pend_id_reg;
        pend_pay_next   = pend_pay_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = '0;
        push            = 1'b0;
        push_val        = '{kind: KIND_GRANT, id: '0, payload: '0, last: 1'b1};

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_idx_reg;
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    item_reply_next = req.req_type;
                    item_id_next    = req.reply_id;
                    item_pay_next   = req.payload_handle;
                    item_zero_next  = (offset == '0);
                    item_win_next   = in_win;
                    item_slot_next  = req_slot;
                    mem_rd_en       = req.req_type;
                    mem_rd_addr     = req_slot;
                    state_next      = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (!item_reply_reg)
                begin
                    push = can_push;
                    if (ooo_reg)
                    begin
                        push_val.kind = KIND_GRANT;
                    end
                    else if (used >= WIN_ID)
                    begin
                        push_val.kind = KIND_FULL;
                        push_val.id   = tail_id_reg;
                    end
                    else
                    begin
                        push_val.kind = KIND_GRANT;
                        push_val.id   = tail_id_reg;
                        if (can_push)
                        begin
                            tail_id_next = tail_id_reg + 1'b1;
                        end
                    end
                    if (can_push)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (ooo_reg || !item_win_reg || mem_rd_data[PAY_W])
                begin
                    // Pass through unordered, or drop as out of window / duplicate.
                    push             = can_push;
                    push_val.kind    = ooo_reg ? KIND_WRITTEN : KIND_REJECTED;
                    push_val.id      = item_id_reg;
                    push_val.payload = item_pay_reg;
                    if (can_push)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!item_zero_reg)
                begin
                    // Hold the reply until the head reaches it.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = item_slot_reg;
                    mem_wr_data = {1'b1, item_pay_reg};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // Reply at the head: advance and look at the next slot.
                    pend_id_next   = item_id_reg;
                    pend_pay_next  = item_pay_reg;
                    head_id_next   = head_id_reg + 1'b1;
                    head_slot_next = head_slot_inc;
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = head_slot_inc;
                    state_next     = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (can_push)
                begin
                    push             = 1'b1;
                    push_val.kind    = KIND_WRITTEN;
                    push_val.id      = pend_id_reg;
                    push_val.payload = pend_pay_reg;
                    push_val.last    = !drain_more;
                    if (drain_more)
                    begin
                        pend_id_next   = head_id_reg;
                        pend_pay_next  = mem_rd_data[PAY_W-1:0];
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = head_slot_reg;
                        head_id_next   = head_id_reg + 1'b1;
                        head_slot_next = head_slot_inc;
                        mem_rd_en      = 1'b1;
                        mem_rd_addr    = head_slot_inc;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ooo_reg       <= 1'b0;
            head_id_reg   <= '0;
            tail_id_reg   <= '0;
            head_slot_reg <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_id_reg   <= head_id_next;
            tail_id_reg   <= tail_id_next;
            head_slot_reg <= head_slot_next;
            clr_idx_reg   <= clr_idx_next;
            if (cfg.valid)
            begin
                ooo_reg <= cfg.out_of_order;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reply_reg <= item_reply_next;
        item_id_reg    <= item_id_next;
        item_pay_reg   <= item_pay_next;
        item_zero_reg  <= item_zero_next;
        item_win_reg   <= item_win_next;
        item_slot_reg  <= item_slot_next;
        pend_id_reg    <= pend_id_next;
        pend_pay_reg   <= pend_pay_next;
        if (push)
        begin
            out_reg <= push_val;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_kind    = out_reg.kind;
    assign rsp.out_id      = out_reg.id;
    assign rsp.out_payload = out_reg.payload;
    assign rsp.last        = out_reg.last;

    `RRB_ASSERT_NEVER(a_no_rw_clash, clk, rst_n, mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr), "slot read and write hit the same entry")
    `RRB_ASSERT(a_window_bound, clk, rst_n, used <= WIN_ID, "outstanding ids exceed the window")
    `RRB_ASSERT(a_slot_bound, clk, rst_n, head_slot_reg <= LAST_SLOT, "head slot pointer out of range")
    `RRB_ASSERT(a_one_item, clk, rst_n, req.valid && req.ready |=> !req.ready, "request taken while another is in flight")

endmodule

/* hdl/reply_reorder_buffer_top.sv */
// Reply reorder buffer: grants sequence ids and releases replies in issue order.
// Timing: a grant or rejection is pushed to the result register from the decide state, a drain's
// first result from the drain state after the next slot is read, then one result per cycle while
// the result register is free, from the registered slot read. A new request is taken only in idle,
// once the last one is through; a full result register that is not read holds the sequencer in place.
// Reset: head, tail and mode clear at once, then a sweep clears the slots.
module reply_reorder_buffer_top #(
    parameter int WINDOW = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    rrb_in_if.sink     req,
    rrb_out_if.source  rsp,
    rrb_cfg_if.sink    cfg
);
    import rrb_pkg::*;

    localparam int SW = $clog2(WINDOW);

    logic             mem_rd_en;
    logic [SW-1:0]    mem_rd_addr;
    logic [PAY_W:0]   mem_rd_data;
    logic             mem_wr_en;
    logic [SW-1:0]    mem_wr_addr;
    logic [PAY_W:0]   mem_wr_data;

    rrb_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    rrb_slot_mem #(
        .WINDOW (WINDOW)
    ) u_slot_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule
